>>> sv/vtpd_pkg.sv
// Shared types, constants and helpers for the vertex transform block.
package vtpd_pkg;
    localparam int NumRegs   = 8;
    localparam int RegIdxW   = 3;
    localparam int CfgW      = 64;
    localparam int CompW     = 32;
    localparam int QuoW      = 48;
    localparam int DivSteps  = 48;
    localparam int BitsPerSt = 4;
    localparam int DivStages = DivSteps / BitsPerSt;

    localparam logic [CfgW-1:0] RstRow0C01 = 64'h0000_0000_0001_0000;
    localparam logic [CfgW-1:0] RstRow1C01 = 64'h0001_0000_0000_0000;
    localparam logic [CfgW-1:0] RstRow2C23 = 64'h0000_0000_0001_0000;
    localparam logic [CfgW-1:0] RstRow3C23 = 64'h0001_0000_0000_0000;

    localparam logic ActPoint  = 1'b0;
    localparam logic ActVector = 1'b1;

    localparam logic signed [CompW-1:0] OneQ16 = 32'sh0001_0000;

    typedef struct packed {
        logic                    point;
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
        logic signed [CompW-1:0] z;
        logic signed [CompW-1:0] w;
    } t_vec;

    typedef struct packed {
        logic                    point;
        logic signed [CompW-1:0] x;
        logic signed [CompW-1:0] y;
        logic signed [CompW-1:0] z;
        logic signed [CompW-1:0] w;
    } t_res;

    // saturate a 50-bit signed value to 32 bits
    function automatic logic signed [CompW-1:0] sat50(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[CompW-1:0];
        end
    endfunction
endpackage

>>> sv/vtpd_dot.sv
// Pipelined 4x4 matrix-vector product with rounding and saturation (3 stages).
module vtpd_dot import vtpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_vec                    i_vec,
    input  logic [CfgW-1:0]         i_regs [NumRegs],
    output logic                    o_valid,
    output t_res                    o_res
);
    logic signed [63:0] r_prod [4][4];
    logic               r_pt1;
    logic               r_v1;
    logic signed [65:0] r_sum [4];
    logic               r_pt2;
    logic               r_v2;
    t_res               r_res;
    logic               r_v3;

    logic signed [CompW-1:0] comp [4];
    logic signed [CompW-1:0] n_elem [4][4];
    logic signed [65:0]      rnd [4];
    logic signed [49:0]      shf [4];

    always_comb begin
        comp[0] = i_vec.x;
        comp[1] = i_vec.y;
        comp[2] = i_vec.z;
        comp[3] = (i_vec.point) ? OneQ16 : i_vec.w;
        for (int r = 0; r < 4; r++) begin
            n_elem[r][0] = i_regs[2*r][31:0];
            n_elem[r][1] = i_regs[2*r][63:32];
            n_elem[r][2] = i_regs[2*r+1][31:0];
            n_elem[r][3] = i_regs[2*r+1][63:32];
        end
        for (int r = 0; r < 4; r++) begin
            rnd[r] = r_sum[r] + 66'sd32768;
            shf[r] = rnd[r][65:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[r][c] <= n_elem[r][c] * comp[c];
                end
                r_sum[r] <= 66'(r_prod[r][0]) + 66'(r_prod[r][1])
                          + 66'(r_prod[r][2]) + 66'(r_prod[r][3]);
            end
            r_pt1       <= i_vec.point;
            r_pt2       <= r_pt1;
            r_res.point <= r_pt2;
            r_res.x     <= sat50(shf[0]);
            r_res.y     <= sat50(shf[1]);
            r_res.z     <= sat50(shf[2]);
            r_res.w     <= sat50(shf[3]);
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;
endmodule

>>> sv/vtpd_div.sv
// Pipelined restoring divider: three lanes of (c*2^16)/w, 4 quotient bits per stage.
module vtpd_div import vtpd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_res   i_res,
    output logic   o_valid,
    output logic signed [CompW-1:0] o_x,
    output logic signed [CompW-1:0] o_y,
    output logic signed [CompW-1:0] o_z,
    output logic signed [CompW-1:0] o_w,
    output logic   o_zero
);
    // per-lane: dividend magnitude shifts out of r_num into remainder
    logic [QuoW-1:0]  r_num [DivStages+1][3];
    logic [CompW:0]   r_rem [DivStages+1][3];
    logic             r_neg [DivStages+1][3];
    logic [CompW-1:0] r_den [DivStages+1];
    t_res             r_res [DivStages+1];
    logic             r_v   [DivStages+1];

    logic [QuoW-1:0]  n_num [DivStages][3];
    logic [CompW:0]   n_rem [DivStages][3];
    logic signed [CompW-1:0] lane_in [3];
    logic [CompW-1:0] wmag;
    logic [CompW:0]   t_r;
    logic [QuoW-1:0]  t_n;
    logic [QuoW:0]    sq;

    always_comb begin
        lane_in[0] = i_res.x;
        lane_in[1] = i_res.y;
        lane_in[2] = i_res.z;
        wmag = i_res.w[CompW-1] ? CompW'(-i_res.w) : CompW'(i_res.w);
        for (int s = 0; s < DivStages; s++) begin
            for (int l = 0; l < 3; l++) begin
                t_r = r_rem[s][l];
                t_n = r_num[s][l];
                for (int b = 0; b < BitsPerSt; b++) begin
                    t_r = {t_r[CompW-1:0], t_n[QuoW-1]};
                    t_n = {t_n[QuoW-2:0], 1'b0};
                    if (t_r >= {1'b0, r_den[s]}) begin
                        t_r   = t_r - {1'b0, r_den[s]};
                        t_n[0] = 1'b1;
                    end
                end
                n_rem[s][l] = t_r;
                n_num[s][l] = t_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DivStages; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < DivStages; s++) r_v[s+1] <= r_v[s];
        end
        if (i_en) begin
            r_res[0] <= i_res;
            r_den[0] <= wmag;
            for (int l = 0; l < 3; l++) begin
                r_num[0][l] <= {(lane_in[l][CompW-1] ? CompW'(-lane_in[l])
                                                     : CompW'(lane_in[l])), 16'h0};
                r_rem[0][l] <= '0;
                r_neg[0][l] <= lane_in[l][CompW-1] ^ i_res.w[CompW-1];
            end
            for (int s = 0; s < DivStages; s++) begin
                r_res[s+1] <= r_res[s];
                r_den[s+1] <= r_den[s];
                for (int l = 0; l < 3; l++) begin
                    r_num[s+1][l] <= n_num[s][l];
                    r_rem[s+1][l] <= n_rem[s][l];
                    r_neg[s+1][l] <= r_neg[s][l];
                end
            end
        end
    end

    logic signed [CompW-1:0] q [3];
    logic signed [CompW-1:0] v_in [3];
    logic zw;
    always_comb begin
        v_in[0] = r_res[DivStages].x;
        v_in[1] = r_res[DivStages].y;
        v_in[2] = r_res[DivStages].z;
        zw = r_res[DivStages].point && (r_res[DivStages].w == '0);
        for (int l = 0; l < 3; l++) begin
            sq = r_neg[DivStages][l] ? (QuoW+1)'(-{1'b0, r_num[DivStages][l]})
                                     : {1'b0, r_num[DivStages][l]};
            if (!r_res[DivStages].point) begin
                q[l] = v_in[l];
            end else if (zw) begin
                q[l] = '0;
            end else if ($signed(sq) > $signed(49'sd2147483647)) begin
                q[l] = 32'sh7FFF_FFFF;
            end else if ($signed(sq) < -$signed(49'sd2147483648)) begin
                q[l] = 32'sh8000_0000;
            end else begin
                q[l] = sq[CompW-1:0];
            end
        end
    end

    assign o_valid = r_v[DivStages];
    assign o_x     = q[0];
    assign o_y     = q[1];
    assign o_z     = q[2];
    assign o_w     = r_res[DivStages].w;
    assign o_zero  = zw;
endmodule

>>> sv/vertex_transform_perspective_divide.sv
// Top level: 4x4 Q16.16 matrix-vector transform with perspective divide.
//
// Input channel: i_valid/o_stall carry one vector request (action, x, y, z, w).
// Output channel: o_valid/i_stall return one result per request, in order.
// The matrix lives in eight 64-bit registers written through i_cfg_we,
// i_cfg_idx and i_cfg_data; write them only while the pipeline is empty.
// One request is taken every cycle while o_stall is low. A request passes the
// product, rounding and saturation stages, then the 48-bit quotient stages (4 bits
// a stage) and one output register on its way to o_valid.
// Reset empties the pipeline and loads the identity matrix.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises so no request is lost or repeated; when the output
// register is empty or being drained, the pipeline advances.
module vertex_transform_perspective_divide import vtpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_action,
    input  logic signed [CompW-1:0] i_in_x,
    input  logic signed [CompW-1:0] i_in_y,
    input  logic signed [CompW-1:0] i_in_z,
    input  logic signed [CompW-1:0] i_in_w,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [CompW-1:0] o_out_x,
    output logic signed [CompW-1:0] o_out_y,
    output logic signed [CompW-1:0] o_out_z,
    output logic signed [CompW-1:0] o_out_w,
    output logic                    o_zero_w_flag,
    input  logic                    i_cfg_we,
    input  logic [RegIdxW:0]        i_cfg_idx,
    input  logic [CfgW-1:0]         i_cfg_data
);
    logic [CfgW-1:0] r_regs [NumRegs];
    logic            en;
    t_vec            vec;
    logic            dot_v;
    t_res            dot_r;
    logic            div_v;
    logic signed [CompW-1:0] dx, dy, dz, dw;
    logic            dzf;
    logic            r_ov;

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;
    assign o_valid = r_ov;

    always_comb begin
        vec.point = (i_action == ActPoint);
        vec.x = i_in_x;
        vec.y = i_in_y;
        vec.z = i_in_z;
        vec.w = i_in_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[0] <= RstRow0C01;
            r_regs[1] <= '0;
            r_regs[2] <= RstRow1C01;
            r_regs[3] <= '0;
            r_regs[4] <= '0;
            r_regs[5] <= RstRow2C23;
            r_regs[6] <= '0;
            r_regs[7] <= RstRow3C23;
        end else if (i_cfg_we && !i_cfg_idx[RegIdxW]) begin
            r_regs[i_cfg_idx[RegIdxW-1:0]] <= i_cfg_data;
        end
    end

    vtpd_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_vec   (vec),
        .i_regs  (r_regs),
        .o_valid (dot_v),
        .o_res   (dot_r)
    );

    vtpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dot_v),
        .i_res   (dot_r),
        .o_valid (div_v),
        .o_x     (dx),
        .o_y     (dy),
        .o_z     (dz),
        .o_w     (dw),
        .o_zero  (dzf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= div_v;
        end
        if (en) begin
            o_out_x       <= dx;
            o_out_y       <= dy;
            o_out_z       <= dz;
            o_out_w       <= dw;
            o_zero_w_flag <= dzf;
        end
    end
endmodule

>>> tb/vertex_transform_perspective_divide_test.sv
// Testbench for the vertex transform block: matrix settings, point and vector requests.
`timescale 1ns / 1ps

module vertex_transform_perspective_divide_test;
    import vtpd_pkg::*;

    typedef struct {
        logic signed [31:0] x, y, z, w;
        logic               flag;
    } t_xform;

    class xform_scoreboard;
        logic [63:0] mat [NumRegs];
        t_xform      pending [$];
        int          mismatches;

        function new();
            mismatches = 0;
            mat[0] = RstRow0C01; mat[1] = '0;
            mat[2] = RstRow1C01; mat[3] = '0;
            mat[4] = '0;         mat[5] = RstRow2C23;
            mat[6] = '0;         mat[7] = RstRow3C23;
        endfunction

        function void write_reg(int idx, logic [63:0] val);
            if (idx < NumRegs) mat[idx] = val;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint row_sum(int r, longint vec [4]);
            logic signed [127:0] acc;
            logic [63:0]         rg;
            logic signed [31:0]  e;
            acc = 0;
            for (int c = 0; c < 4; c++) begin
                rg  = mat[r*2 + c/2];
                e   = (c % 2) ? rg[63:32] : rg[31:0];
                acc = acc + 128'(e) * 128'(vec[c]);
            end
            acc = (acc + 128'sd32768) >>> 16;
            if (acc > 128'sd2147483647) return 64'sd2147483647;
            if (acc < -128'sd2147483648) return -64'sd2147483648;
            return longint'(acc);
        endfunction

        function void note_request(logic act, logic signed [31:0] x, y, z, w);
            longint vec [4];
            longint res [4];
            t_xform t;
            vec[0] = x; vec[1] = y; vec[2] = z;
            vec[3] = (act == ActPoint) ? 64'sd65536 : longint'(w);
            for (int i = 0; i < 4; i++) res[i] = row_sum(i, vec);
            t.flag = 1'b0;
            if (act == ActPoint) begin
                if (res[3] == 0) begin
                    t.flag = 1'b1;
                    res[0] = 0; res[1] = 0; res[2] = 0;
                end else begin
                    for (int i = 0; i < 3; i++) res[i] = clamp((res[i] * 65536) / res[3]);
                end
            end
            t.x = res[0][31:0]; t.y = res[1][31:0]; t.z = res[2][31:0]; t.w = res[3][31:0];
            pending.push_back(t);
        endfunction

        function void check_result(logic signed [31:0] x, y, z, w, logic f);
            t_xform e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result x=%0d", x);
                return;
            end
            e = pending.pop_front();
            if (e.x !== x || e.y !== y || e.z !== z || e.w !== w || e.flag !== f) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("exp %0d %0d %0d %0d %b got %0d %0d %0d %0d %b",
                             e.x, e.y, e.z, e.w, e.flag, x, y, z, w, f);
            end
        endfunction
    endclass

    logic               i_clk = 0, i_rst_n = 0;
    logic               i_valid = 0, i_stall = 0, i_action = 0;
    logic signed [31:0] i_in_x = 0, i_in_y = 0, i_in_z = 0, i_in_w = 0;
    logic               i_cfg_we = 0;
    logic [RegIdxW:0]   i_cfg_idx = 0;
    logic [63:0]        i_cfg_data = 0;
    logic               o_stall, o_valid, o_zero_w_flag;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_w;

    xform_scoreboard sb = new();
    bit  hold_rx = 0, sending = 1;
    int  idle_cycles = 0;

    vertex_transform_perspective_divide uut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'($urandom_range(0, 8)) <<< 16;
            3: return -(32'($urandom_range(0, 8)) <<< 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_row();
        logic [31:0] h [2];
        for (int i = 0; i < 2; i++)
            case ($urandom_range(0, 4))
                0: h[i] = 32'h0001_0000;
                1: h[i] = 32'h0;
                2: h[i] = 32'($signed($urandom_range(0, 6)) - 3) <<< 15;
                3: h[i] = $urandom_range(0, 131071) - 65536;
                default: h[i] = $urandom;
            endcase
        return {h[1], h[0]};
    endfunction

    // receiver and checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_out_x, o_out_y, o_out_z, o_out_w, o_zero_w_flag);
    end

    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) i_stall <= 1'b1;
            else if (g > 0) begin i_stall <= 1'b1; g--; end
            else begin i_stall <= 1'b0; g = ($urandom_range(0, 3) == 0) ? gap_len() : 0; end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || i_cfg_we)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // leaves i_valid high; the caller drops it before any idle cycle
    task automatic send(logic act, logic signed [31:0] x, y, z, w);
        i_cfg_we <= 0;
        i_valid <= 1; i_action <= act;
        i_in_x <= x; i_in_y <= y; i_in_z <= z; i_in_w <= w;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(act, x, y, z, w);
        @(negedge i_clk);
    endtask

    task automatic send_gap(logic act, logic signed [31:0] x, y, z, w);
        int g;
        send(act, x, y, z, w);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // leaves i_cfg_we high; the next send drops it
    task automatic cfg_write(int idx, logic [63:0] val);
        i_cfg_we <= 1; i_cfg_idx <= (RegIdxW+1)'(idx); i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic rand_phase(int n);
        for (int k = 0; k < n; k++)
            send_gap($urandom_range(0, 1), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        // identity: extremes, both modes
        send(ActPoint, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000);
        send(ActVector, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 32'sh7FFF_FFFF);
        send(ActVector, 0, 0, 0, 0);
        send(ActPoint, 32'sh0003_8000, -32'sh0002_0000, 32'sh1, 0);
        drain();
        // w row zero: flag case; w row negative: divide signs
        cfg_write(6, 64'h0); cfg_write(7, 64'h0);
        send(ActPoint, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0);
        drain();
        cfg_write(7, 64'h0000_0000_0000_0001);  // tiny w rounds to zero
        send(ActPoint, 32'sh0001_0000, -1, 7, 0);
        drain();
        cfg_write(6, 64'h0000_0000_FFFF_8000);  // w = -x/2: tiny divisor, saturation
        cfg_write(7, 64'h0000_0000_0000_0000);
        send(ActPoint, 32'sh0000_0002, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send(ActPoint, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send(ActPoint, 32'sh0000_0001, 32'sh0000_0001, -32'sh0000_0001, 0);
        send(ActVector, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        drain();
        // all registers at extremes
        for (int r = 0; r < NumRegs; r++) cfg_write(r, 64'h7FFF_FFFF_8000_0000);
        send(ActVector, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send(ActPoint, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        drain();
        for (int r = 0; r < NumRegs; r++) cfg_write(r, 64'hFFFF_FFFF_FFFF_FFFF);
        send(ActVector, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 32'sh0001_0000);
        send(ActPoint, 32'sh0005_0000, 32'sh0001_0000, 32'sh0, 0);
        drain();
        cfg_write(8, 64'h1234);  // out of range index
        send(ActPoint, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0);
        drain();
        // random phases with random matrices
        for (int ph = 0; ph < 5; ph++) begin
            for (int r = 0; r < NumRegs; r++) cfg_write(r, rand_row());
            if (ph == 2) begin
                fork
                    begin hold_rx = 1; repeat (60) @(negedge i_clk); hold_rx = 0; end
                    for (int k = 0; k < 40; k++)
                        send(ActVector, rand_comp(), rand_comp(), rand_comp(), rand_comp());
                join
            end
            rand_phase(70);
            drain();
        end
        // back to identity-like reset values
        cfg_write(0, RstRow0C01); cfg_write(1, 0); cfg_write(2, RstRow1C01); cfg_write(3, 0);
        cfg_write(4, 0); cfg_write(5, RstRow2C23); cfg_write(6, 0); cfg_write(7, RstRow3C23);
        rand_phase(20);
        drain();
        repeat (10) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> filelist.f
sv/vtpd_pkg.sv
sv/vtpd_dot.sv
sv/vtpd_div.sv
sv/vertex_transform_perspective_divide.sv
tb/vertex_transform_perspective_divide_test.sv
